/* hw/rtl/prpc_pkg.sv */
// shared constants for the pairwise row correlation unit
// no dependencies; imported by the top level, the divider and the checker
package prpc_pkg;

    // configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // request kinds carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    // result format, signed q2.16
    localparam int CORR_W    = 18;
    localparam int ROW_W     = 7;
    localparam int FRAC_BITS = 16;
    localparam int OUT_TD_W  = ((CORR_W + 2 * ROW_W + 7) / 8) * 8;
    localparam int unsigned CORR_ONE = 65536;

    // quotient bits kept by the divider (ratio stays below eight)
    localparam int QUO_BITS = 19;

endpackage

/* hw/rtl/pairwise_row_pearson_correlation_unit.sv */
// top level: sample store, row statistics store and the sequencer
// depends on prpc_pkg, prpc_ram, prpc_sqrt, prpc_div
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser command, tdata sample
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata corr/rows, tuser undef, tlast
//  cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
// the last load of a matrix starts the statistics pass, a column walk and
// a 24-bit root for each row (one bit a cycle); a pair request walks one
// column a cycle through the dual read port of the sample ram, then the
// divider for 19 quotient bits; a pair with a zero-spread row skips both
// s_axis_tready is low while a request is at work; a result waiting in the
// output register holds the sequencer only when the next result is due
// reset clears control state; the stores are not cleared
module pairwise_row_pearson_correlation_unit #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLS    = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_value, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [17:0] correlation, [24:18] first_row, [31:25] second_row
    output logic [prpc_pkg::OUT_TD_W-1:0]  m_axis_tdata,
    // [0] undefined
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [prpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [prpc_pkg::CFG_W-1:0]     i_cfg_data
);
    import prpc_pkg::*;

    localparam int SW    = SAMPLE_BITS;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int IW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int SXW   = SW + CW;
    localparam int ACCW  = 2 * SW + CW + 1;
    localparam int SPW   = 2 * SW + 2 * CW;
    localparam int NW    = SPW / 2;
    localparam int STW   = SXW + NW;
    localparam int NUMW  = SPW + 2;
    localparam int MAGW  = SPW + 1;
    localparam int DNW   = MAGW + FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SUM    = 11'b000_0000_0010,
        S_SPREAD = 11'b000_0000_0100,
        S_SQRT   = 11'b000_0000_1000,
        S_PUT    = 11'b000_0001_0000,
        S_RDST   = 11'b000_0010_0000,
        S_CHK    = 11'b000_0100_0000,
        S_NUM    = 11'b000_1000_0000,
        S_SUB    = 11'b001_0000_0000,
        S_DIV    = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]       r_rows_cfg, r_cols_cfg;
    logic [RW-1:0]          eff_rows;
    logic [CW-1:0]          eff_cols;
    logic [RW+CW-1:0]       total_full;
    logic [LW-1:0]          total;
    logic [LW-1:0]          r_load_cnt;
    logic [LW-1:0]          load_idx, load_next;
    logic                   load_done;
    logic                   r_ready;
    logic [IW-1:0]          r_a, r_b;
    logic [AW-1:0]          r_base_a, r_base_b;
    logic [RW-1:0]          r_row;
    logic [AW-1:0]          r_addr;
    logic [CW-1:0]          r_col;
    logic                   r_rdv;
    logic signed [ACCW-1:0] r_acc1, r_acc2;
    logic signed [NUMW-1:0] r_p1, r_p2;
    logic [SPW-1:0]         r_den;
    logic [MAGW-1:0]        r_mag;
    logic                   r_neg;
    logic signed [SXW-1:0]  r_sa, r_sb;
    logic [NW-1:0]          r_na, r_nb;
    logic                   r_undef;
    logic                   r_go;
    logic                   r_ovalid;
    logic [CORR_W-1:0]      r_ocorr;
    logic [ROW_W-1:0]       r_ofirst, r_osecond;
    logic                   r_oundef, r_olast;

    logic                   in_fire, out_free, rows_ok, sum_done;
    logic [SW-1:0]          smp_wr;
    logic [AW-1:0]          smp_raddr_a, smp_raddr_b;
    logic [SW-1:0]          smp_rd_a, smp_rd_b;
    logic signed [SW-1:0]   smp_a, smp_b;
    logic signed [2*SW-1:0] prod_ab, prod_aa;
    logic [STW-1:0]         st_rd_a, st_rd_b;
    logic signed [SXW-1:0]  ms_a, ms_b;
    logic signed [ACCW-1:0] mc_sel;
    logic signed [NUMW-1:0] mul_c;
    logic signed [2*SXW-1:0] mul_s;
    logic [SPW-1:0]         mul_n;
    logic signed [NUMW-1:0] diff;
    logic [SPW-1:0]         spread;
    logic                   sq_done;
    logic [NW-1:0]          sq_root;
    logic [DNW-1:0]         div_num;
    logic                   div_done;
    logic [QUO_BITS-1:0]    quo;
    logic [CORR_W-1:0]      cmag, corr;
    logic [RW-1:0]          a1, b1;
    logic                   is_last;

    // effective sizes, out-of-range settings clamped
    always_comb begin
        if (r_rows_cfg == '0) begin
            eff_rows = RW'(1);
        end else if (32'(r_rows_cfg) > MAX_ROWS) begin
            eff_rows = RW'(MAX_ROWS);
        end else begin
            eff_rows = RW'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            eff_cols = CW'(1);
        end else if (32'(r_cols_cfg) > MAX_COLS) begin
            eff_cols = CW'(MAX_COLS);
        end else begin
            eff_cols = CW'(r_cols_cfg);
        end
    end

    assign total_full = eff_rows * eff_cols;
    assign total      = LW'(total_full);
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_ovalid || m_axis_tready;
    assign rows_ok    = eff_rows >= RW'(2);
    assign load_idx   = r_ready ? '0 : r_load_cnt;
    assign load_next  = load_idx + LW'(1);
    assign load_done  = load_next >= total;
    assign sum_done   = (r_col == eff_cols) && !r_rdv;

    // sample store
    assign smp_wr      = s_axis_tdata[SW-1:0];
    assign smp_raddr_a = (r_ready) ? r_base_a + AW'(r_col) : r_addr;
    assign smp_raddr_b = r_base_b + AW'(r_col);

    prpc_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_samples (
        .i_clk     (i_clk),
        .i_we      (in_fire && (s_axis_tuser == CMD_LOAD)),
        .i_waddr   (load_idx[AW-1:0]),
        .i_wdata   (smp_wr),
        .i_raddr_a (smp_raddr_a),
        .i_raddr_b (smp_raddr_b),
        .o_rdata_a (smp_rd_a),
        .o_rdata_b (smp_rd_b)
    );

    // row statistics store: row sum above row norm
    prpc_ram #(.WIDTH(STW), .DEPTH(MAX_ROWS)) u_stats (
        .i_clk     (i_clk),
        .i_we      (r_state == S_PUT),
        .i_waddr   (r_row[IW-1:0]),
        .i_wdata   ({SXW'(r_acc1), sq_root}),
        .i_raddr_a (r_a),
        .i_raddr_b (r_b),
        .o_rdata_a (st_rd_a),
        .o_rdata_b (st_rd_b)
    );

    // products
    assign smp_a   = $signed(smp_rd_a);
    assign smp_b   = $signed(smp_rd_b);
    assign prod_ab = smp_a * smp_b;
    assign prod_aa = smp_a * smp_a;
    assign ms_a    = r_ready ? r_sa : SXW'(r_acc1);
    assign ms_b    = r_ready ? r_sb : SXW'(r_acc1);
    assign mc_sel  = r_ready ? r_acc1 : r_acc2;
    assign mul_c   = $signed({1'b0, eff_cols}) * mc_sel;
    assign mul_s   = ms_a * ms_b;
    assign mul_n   = r_na * r_nb;
    assign diff    = r_p1 - r_p2;
    assign spread  = diff[NUMW-1] ? '0 : SPW'(diff);
    assign div_num = {r_mag, {FRAC_BITS{1'b0}}} + DNW'(r_den >> 1);

    prpc_sqrt #(.IN_W(SPW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go && (r_state == S_SQRT)),
        .i_radicand (spread),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    prpc_div #(.NUM_W(DNW), .DEN_W(SPW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_DIV)),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // rounding already folded in; saturate to one and apply the sign
    assign cmag = (quo > QUO_BITS'(CORR_ONE)) ? CORR_W'(CORR_ONE) : CORR_W'(quo);
    assign corr = r_neg ? -cmag : cmag;

    // pair walk
    assign a1      = RW'(r_a) + RW'(1);
    assign b1      = RW'(r_b) + RW'(1);
    assign is_last = (RW'(r_a) == eff_rows - RW'(2)) && (RW'(r_b) == eff_rows - RW'(1));

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == CMD_LOAD) begin
                        if (load_done) n_state = S_SUM;
                    end else if (r_ready && rows_ok) begin
                        n_state = S_RDST;
                    end
                end
            end
            S_SUM: begin
                if (sum_done) n_state = r_ready ? S_NUM : S_SPREAD;
            end
            S_SPREAD: n_state = S_SQRT;
            S_SQRT: begin
                if (sq_done) n_state = S_PUT;
            end
            S_PUT: begin
                n_state = (r_row + RW'(1) == eff_rows) ? S_IDLE : S_SUM;
            end
            S_RDST: n_state = S_CHK;
            S_CHK: begin
                if ((st_rd_a[NW-1:0] == '0) || (st_rd_b[NW-1:0] == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_NUM: n_state = S_SUB;
            S_SUB: n_state = S_DIV;
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rows_cfg <= CFG_W'(128);
            r_cols_cfg <= CFG_W'(128);
            r_load_cnt <= '0;
            r_ready    <= 1'b0;
            r_a        <= '0;
            r_b        <= IW'(1);
            r_go       <= 1'b0;
            r_rdv      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= ((n_state == S_SQRT) && (r_state != S_SQRT))
                    || ((n_state == S_DIV) && (r_state != S_DIV));
            if (m_axis_tready) r_ovalid <= 1'b0;

            // configuration write restarts loading
            if (i_cfg_we && ((i_cfg_idx == REG_ROWS) || (i_cfg_idx == REG_COLS))) begin
                if (i_cfg_idx == REG_ROWS) r_rows_cfg <= i_cfg_data;
                else                       r_cols_cfg <= i_cfg_data;
                r_load_cnt <= '0;
                r_ready    <= 1'b0;
                r_a        <= '0;
                r_b        <= IW'(1);
            end else if (in_fire && (s_axis_tuser == CMD_LOAD)) begin
                r_load_cnt <= load_next;
                r_ready    <= 1'b0;
            end

            // statistics done: pair walk from the start
            if ((r_state == S_PUT) && (n_state == S_IDLE)) begin
                r_ready <= 1'b1;
                r_a     <= '0;
                r_b     <= IW'(1);
            end

            // sample read pipeline
            if (r_state == S_SUM) begin
                r_rdv <= r_col != eff_cols;
            end else begin
                r_rdv <= 1'b0;
            end

            // result out and step to the next pair
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
                if (b1 >= eff_rows) begin
                    if (a1 >= eff_rows - RW'(1)) begin
                        r_a <= '0;
                        r_b <= IW'(1);
                    end else begin
                        r_a <= IW'(a1);
                        r_b <= IW'(a1 + RW'(1));
                    end
                end else begin
                    r_b <= IW'(b1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_row  <= '0;
                r_addr <= '0;
                r_col  <= '0;
                r_acc1 <= '0;
                r_acc2 <= '0;
            end
            S_SUM: begin
                if (r_col != eff_cols) begin
                    r_col  <= r_col + CW'(1);
                    r_addr <= r_addr + AW'(1);
                end
                if (r_rdv) begin
                    if (r_ready) begin
                        r_acc1 <= r_acc1 + ACCW'(prod_ab);
                    end else begin
                        r_acc1 <= r_acc1 + ACCW'(smp_a);
                        r_acc2 <= r_acc2 + ACCW'(prod_aa);
                    end
                end
            end
            S_SPREAD, S_NUM: begin
                r_p1  <= mul_c;
                r_p2  <= NUMW'(mul_s);
                r_den <= mul_n;
            end
            S_PUT: begin
                r_row  <= r_row + RW'(1);
                r_col  <= '0;
                r_acc1 <= '0;
                r_acc2 <= '0;
            end
            S_CHK: begin
                r_sa    <= $signed(st_rd_a[STW-1:NW]);
                r_sb    <= $signed(st_rd_b[STW-1:NW]);
                r_na    <= st_rd_a[NW-1:0];
                r_nb    <= st_rd_b[NW-1:0];
                r_undef <= (st_rd_a[NW-1:0] == '0) || (st_rd_b[NW-1:0] == '0);
                r_col   <= '0;
                r_acc1  <= '0;
            end
            S_SUB: begin
                r_neg <= diff[NUMW-1];
                r_mag <= diff[NUMW-1] ? MAGW'(-diff) : MAGW'(diff);
            end
            default: begin
            end
        endcase

        // output register payload
        if ((r_state == S_OUT) && out_free) begin
            r_ocorr   <= r_undef ? '0 : corr;
            r_ofirst  <= ROW_W'(r_a);
            r_osecond <= ROW_W'(r_b);
            r_oundef  <= r_undef;
            r_olast   <= is_last;
        end
    end

    // column bases of the current pair
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUT) && (n_state == S_IDLE)) begin
            r_base_a <= '0;
            r_base_b <= AW'(eff_cols);
        end else if ((r_state == S_OUT) && out_free) begin
            if (b1 >= eff_rows) begin
                if (a1 >= eff_rows - RW'(1)) begin
                    r_base_a <= '0;
                    r_base_b <= AW'(eff_cols);
                end else begin
                    r_base_a <= r_base_a + AW'(eff_cols);
                    r_base_b <= r_base_a + AW'(eff_cols) + AW'(eff_cols);
                end
            end else begin
                r_base_b <= r_base_b + AW'(eff_cols);
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_TD_W'({r_osecond, r_ofirst, r_ocorr});
    assign m_axis_tuser  = r_oundef;
    assign m_axis_tlast  = r_olast;
endmodule

/* hw/rtl/prpc_ram.sv */
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module prpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

/* hw/rtl/prpc_sqrt.sv */
// iterative integer square root, one result bit per cycle
// no dependencies
module prpc_sqrt #(
    parameter int IN_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_radicand,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);
    localparam int RT_W  = IN_W / 2;
    localparam int RM_W  = RT_W + 1;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IN_W-1:0]  r_rad;
    logic [RM_W-1:0]  r_rem;
    logic [RT_W-1:0]  r_root;
    logic [RT_W+1:0]  rem_sh;
    logic [RT_W+1:0]  trial;
    logic [RT_W+1:0]  diff;
    logic             fits;

    // trial subtract for the next root bit
    assign rem_sh = {r_rem[RT_W-1:0], r_rad[IN_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= fits ? RM_W'(diff) : RM_W'(rem_sh);
            r_root <= {r_root[RT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* hw/rtl/prpc_div.sv */
// restoring divider, one quotient bit per cycle
// depends on prpc_pkg for the quotient width
module prpc_div #(
    parameter int NUM_W = 65,
    parameter int DEN_W = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic                          o_done,
    output logic [prpc_pkg::QUO_BITS-1:0] o_quo
);
    import prpc_pkg::*;

    localparam int CNT_W = $clog2(QUO_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [QUO_BITS-1:0] r_low;
    logic [QUO_BITS-1:0] r_quo;
    logic [DEN_W:0]      sh;
    logic [DEN_W:0]      sub;
    logic                fits;

    // trial subtract
    assign sh   = {r_rem, r_low[QUO_BITS-1]};
    assign fits = sh >= {1'b0, r_den};
    assign sub  = sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // upper numerator bits are known to lie below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num[NUM_W-1:QUO_BITS]);
            r_low <= i_num[QUO_BITS-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(sub) : DEN_W'(sh);
            r_low <= r_low << 1;
            r_quo <= {r_quo[QUO_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* hw/rtl/prpc_checker.sv */
// port-level checks on the result channel of the correlation unit
// depends on prpc_pkg; bound to pairwise_row_pearson_correlation_unit
module prpc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [prpc_pkg::OUT_TD_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);
    import prpc_pkg::*;

    logic signed [CORR_W-1:0] corr;
    logic [ROW_W-1:0]         first_row, second_row;

    assign corr       = $signed(m_axis_tdata[CORR_W-1:0]);
    assign first_row  = m_axis_tdata[CORR_W+ROW_W-1:CORR_W];
    assign second_row = m_axis_tdata[CORR_W+2*ROW_W-1:CORR_W+ROW_W];

    // a stalled result stays valid and holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // coefficient saturated to plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (corr <= 18'sd65536) && (corr >= -18'sd65536))
        else $error("coefficient out of range");

    // zero spread gives a zero coefficient
    a_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> corr == '0)
        else $error("undefined pair with non-zero coefficient");

    // pair order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> second_row > first_row)
        else $error("pair out of order");

    // final pair is adjacent rows
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> second_row == first_row + ROW_W'(1))
        else $error("last pair not adjacent");
endmodule

bind pairwise_row_pearson_correlation_unit prpc_checker u_prpc_checker (.*);
